// File: sv/line_fixed_string_matcher_macros.svh
// Assertion macros for the line fixed-string matcher.
// Included by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef LINE_FIXED_STRING_MATCHER_MACROS_SVH
`define LINE_FIXED_STRING_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lfsm_pkg.sv
// Shared types, constants and byte helpers for the line fixed-string matcher.
// No dependencies.
package lfsm_pkg;

    localparam int unsigned PAT_REG_BYTES = 16;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned LEN_W         = 5;
    localparam int unsigned OUT_CNT_W     = 32;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] NUL_BYTE     = 8'h00;
    localparam logic [7:0] CHAR_UC_A    = 8'h41;
    localparam logic [7:0] CHAR_UC_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LC_A    = 8'h61;
    localparam logic [7:0] CHAR_LC_Z    = 8'h7A;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_USCORE  = 8'h5F;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW     = 3'd0,
        CFG_PAT_HIGH    = 3'd1,
        CFG_PAT_LEN     = 3'd2,
        CFG_IGNORE_CASE = 3'd3,
        CFG_WHOLE_WORD  = 3'd4,
        CFG_INVERT      = 3'd5
    } t_cfg_idx;

    typedef logic [PAT_REG_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_slot;

    typedef struct packed {
        logic eq_ok;
        logic bnd_ok;
    } t_cell_flags;

    typedef struct packed {
        logic                 sel;
        logic [OUT_CNT_W-1:0] number;
        logic [OUT_CNT_W-1:0] count;
        logic                 binary;
    } t_result;

    function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
        if (ic && (b inside {[CHAR_UC_A:CHAR_UC_Z]})) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return (b inside {[CHAR_LC_A:CHAR_LC_Z]}) || (b inside {[CHAR_UC_A:CHAR_UC_Z]}) ||
               (b inside {[CHAR_0:CHAR_9]}) || (b == CHAR_USCORE);
    endfunction

endpackage

// File: sv/lfsm_cell.sv
// One window cell: holds one byte of the current line and shifts it onward.
// Compares the byte it loads against its aligned pattern byte. Uses lfsm_pkg.
module lfsm_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic                         i_clear,
    input  lfsm_pkg::t_slot              i_prev,
    input  lfsm_pkg::t_pattern           i_pat,
    input  logic [lfsm_pkg::LEN_W-1:0]   i_len,
    input  logic                         i_ignore_case,
    output lfsm_pkg::t_slot              o_slot,
    output lfsm_pkg::t_cell_flags        o_flags
);

    logic                       r_valid;
    logic [7:0]                 r_data;
    logic [lfsm_pkg::LEN_W-1:0] pat_idx;
    logic [7:0]                 pat_byte;
    logic                       in_pattern;
    logic                       at_boundary;

    always_comb begin
        in_pattern  = int'(i_len) > int'(IDX);
        at_boundary = int'(i_len) == int'(IDX);
        pat_idx     = lfsm_pkg::LEN_W'(int'(i_len) - 1 - int'(IDX));
        pat_byte    = pat_idx[lfsm_pkg::LEN_W-1] ? 8'h00
                                                : i_pat[pat_idx[lfsm_pkg::LEN_W-2:0]];
        o_flags.eq_ok  = !in_pattern ||
                         (i_prev.valid && (lfsm_pkg::fold(i_prev.data, i_ignore_case) ==
                                           lfsm_pkg::fold(pat_byte, i_ignore_case)));
        o_flags.bnd_ok = !at_boundary || !i_prev.valid || !lfsm_pkg::is_word(i_prev.data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_prev.data;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.data  = r_data;

endmodule

// File: sv/line_fixed_string_matcher.sv
// Line fixed-string matcher: one text byte per cycle, one result per line end or
// NUL byte, held in the output register or, while that is full, the skid entry.
// Throughput is one byte per cycle; input stalls only while both the output
// register and the skid entry hold results. The compare is combinational across
// the PATTERN_MAX+1 cells. Synchronous reset clears config and control state.
module line_fixed_string_matcher #(
    parameter int unsigned PATTERN_MAX = 16,
    parameter int unsigned COUNT_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_flush,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_line_selected,
    output logic [lfsm_pkg::OUT_CNT_W-1:0]    o_line_number,
    output logic [lfsm_pkg::OUT_CNT_W-1:0]    o_selected_count,
    output logic                              o_binary_file,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lfsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfsm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

`include "line_fixed_string_matcher_macros.svh"

    localparam int unsigned NUM_CELLS = PATTERN_MAX + 1;

    logic [lfsm_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [lfsm_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [lfsm_pkg::LEN_W-1:0]      r_pat_len;
    logic                            r_ignore_case;
    logic                            r_whole_word;
    logic                            r_invert;

    logic                  r_pending, n_pending;
    logic                  r_hit, n_hit;
    logic                  r_line_open, n_line_open;
    logic                  r_stopped, n_stopped;
    logic [COUNT_BITS-1:0] r_line_cnt, n_line_cnt;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;

    logic                  r_out_valid;
    lfsm_pkg::t_result     r_out;
    logic                  r_skid_valid;
    lfsm_pkg::t_result     r_skid;

    lfsm_pkg::t_pattern          pattern;
    logic [lfsm_pkg::LEN_W-1:0]  eff_len;
    lfsm_pkg::t_slot             chain [NUM_CELLS+1];
    lfsm_pkg::t_cell_flags       flags [NUM_CELLS];
    logic                        eq_all;
    logic                        bnd_all;
    logic                        match;

    logic                  accept;
    logic                  active;
    logic                  is_nul;
    logic                  is_nl;
    logic                  is_txt;
    logic                  end_line;
    logic                  shift;
    logic                  clear;
    logic                  res_v;
    logic                  line_hit_now;
    logic                  sel;
    logic [COUNT_BITS-1:0] line_cnt_inc;
    logic [COUNT_BITS-1:0] hit_cnt_inc;
    lfsm_pkg::t_result     res;
    logic                  out_take;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [lfsm_pkg::OUT_CNT_W-1:0] clamp_out(
        input logic [COUNT_BITS-1:0] v
    );
        logic [63:0] w;
        w = 64'(v);
        return (|w[63:lfsm_pkg::OUT_CNT_W]) ? '1 : w[lfsm_pkg::OUT_CNT_W-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo      <= '0;
            r_pat_hi      <= '0;
            r_pat_len     <= '0;
            r_ignore_case <= 1'b0;
            r_whole_word  <= 1'b0;
            r_invert      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lfsm_pkg::t_cfg_idx'(i_cfg_index))
                lfsm_pkg::CFG_PAT_LOW:     r_pat_lo      <= i_cfg_data;
                lfsm_pkg::CFG_PAT_HIGH:    r_pat_hi      <= i_cfg_data;
                lfsm_pkg::CFG_PAT_LEN:     r_pat_len     <= i_cfg_data[lfsm_pkg::LEN_W-1:0];
                lfsm_pkg::CFG_IGNORE_CASE: r_ignore_case <= i_cfg_data[0];
                lfsm_pkg::CFG_WHOLE_WORD:  r_whole_word  <= i_cfg_data[0];
                lfsm_pkg::CFG_INVERT:      r_invert      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign pattern = lfsm_pkg::t_pattern'({r_pat_hi, r_pat_lo});
    assign eff_len = (int'(r_pat_len) > int'(PATTERN_MAX)) ? lfsm_pkg::LEN_W'(PATTERN_MAX)
                                                           : r_pat_len;

    assign accept   = i_valid && !o_stall;
    assign active   = accept && !r_stopped;
    assign is_nul   = !i_flush && (i_data_byte == lfsm_pkg::NUL_BYTE);
    assign is_nl    = !i_flush && (i_data_byte == lfsm_pkg::NEWLINE_BYTE);
    assign is_txt   = !i_flush && !is_nul && !is_nl;
    assign end_line = (i_flush && r_line_open) || is_nl;
    assign shift    = active && is_txt;
    assign clear    = active && (end_line || is_nul);
    assign res_v    = clear;

    assign chain[0].valid = 1'b1;
    assign chain[0].data  = i_data_byte;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        lfsm_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (shift),
            .i_clear       (clear),
            .i_prev        (chain[k]),
            .i_pat         (pattern),
            .i_len         (eff_len),
            .i_ignore_case (r_ignore_case),
            .o_slot        (chain[k+1]),
            .o_flags       (flags[k])
        );
    end

    always_comb begin
        eq_all  = 1'b1;
        bnd_all = 1'b1;
        for (int k = 0; k < NUM_CELLS; k++) begin
            eq_all  = eq_all && flags[k].eq_ok;
            bnd_all = bnd_all && flags[k].bnd_ok;
        end
    end

    assign match = (eff_len != '0) && eq_all;

    always_comb begin
        line_hit_now = (eff_len == '0) || r_hit || r_pending;
        sel          = line_hit_now ^ r_invert;
        line_cnt_inc = sat_inc(r_line_cnt);
        hit_cnt_inc  = sel ? sat_inc(r_hit_cnt) : r_hit_cnt;

        n_pending   = r_pending;
        n_hit       = r_hit;
        n_line_open = r_line_open;
        n_stopped   = r_stopped;
        n_line_cnt  = r_line_cnt;
        n_hit_cnt   = r_hit_cnt;

        res.sel    = 1'b0;
        res.number = clamp_out(line_cnt_inc);
        res.count  = clamp_out(r_hit_cnt);
        res.binary = 1'b1;

        if (shift) begin
            n_line_open = 1'b1;
            n_hit       = r_hit || (r_pending && !lfsm_pkg::is_word(i_data_byte)) ||
                          (match && !r_whole_word);
            n_pending   = match && r_whole_word && bnd_all;
        end else if (clear) begin
            n_line_open = 1'b0;
            n_hit       = 1'b0;
            n_pending   = 1'b0;
            if (is_nul) begin
                n_stopped = 1'b1;
            end else begin
                n_line_cnt = line_cnt_inc;
                n_hit_cnt  = hit_cnt_inc;
                res.sel    = sel;
                res.count  = clamp_out(hit_cnt_inc);
                res.binary = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_hit       <= 1'b0;
            r_line_open <= 1'b0;
            r_stopped   <= 1'b0;
            r_line_cnt  <= '0;
            r_hit_cnt   <= '0;
        end else begin
            r_pending   <= n_pending;
            r_hit       <= n_hit;
            r_line_open <= n_line_open;
            r_stopped   <= n_stopped;
            r_line_cnt  <= n_line_cnt;
            r_hit_cnt   <= n_hit_cnt;
        end
    end

    assign out_take = r_out_valid && !i_stall;

    // Output register plus one skid entry; hold on stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_v) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_v) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_line_selected  = r_out.sel;
    assign o_line_number    = r_out.number;
    assign o_selected_count = r_out.count;
    assign o_binary_file    = r_out.binary;

    `LFSM_ASSERT_NOW(a_skid_implies_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `LFSM_ASSERT_NOW(a_no_result_when_stopped, r_stopped, !res_v, "result after stop")
    `LFSM_ASSERT_NEXT(a_nul_stops, active && is_nul, r_stopped && !r_line_open, "no stop on NUL")
    `LFSM_ASSERT_NEXT(a_nul_result, active && is_nul, r_out_valid, "no result for NUL")

endmodule
